// ----- rtl/tae_pkg.sv -----
// Shared types, request codes and helper functions for the ANSI escape encoder.
package tae_pkg;

    localparam logic [1:0] REQ_CHAR   = 2'd0;
    localparam logic [1:0] REQ_ATTR   = 2'd1;
    localparam logic [1:0] REQ_CURSOR = 2'd2;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_FIVE  = 8'h35;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        K_CHAR   = 2'd0,
        K_ATTR   = 2'd1,
        K_CURSOR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [7:0] row;
        logic [7:0] col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    // Decimal digits of a cursor number (1..256)
    typedef struct packed {
        logic [1:0] h;
        logic [3:0] t;
        logic [3:0] o;
    } t_dec;

    // Classified work for the emitter: data is the character or the attribute
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_dec       row;
        t_dec       col;
    } t_desc;

    typedef struct packed {
        logic  push;
        t_desc desc;
    } t_push;

    // Split v+1 into hundreds, tens and units
    function automatic t_dec to_dec(input logic [7:0] v);
        logic [8:0]  w;
        logic [8:0]  hund;
        logic [6:0]  r;
        logic [13:0] prod;
        logic [6:0]  tens10;
        t_dec        d;
        w = {1'b0, v} + 9'd1;
        if (w >= 9'd200) begin
            d.h  = 2'd2;
            hund = 9'd200;
        end else if (w >= 9'd100) begin
            d.h  = 2'd1;
            hund = 9'd100;
        end else begin
            d.h  = 2'd0;
            hund = 9'd0;
        end
        r      = 7'(w - hund);
        prod   = 14'(r) * 14'd103;
        d.t    = prod[13:10];
        tens10 = 7'(d.t) * 7'd10;
        d.o    = 4'(r - tens10);
        return d;
    endfunction

    // BIOS colour code to ANSI colour digit
    function automatic logic [7:0] colour_digit(input logic [2:0] c);
        logic [2:0] m;
        case (c)
            3'd0: m = 3'd0;
            3'd1: m = 3'd4;
            3'd2: m = 3'd2;
            3'd3: m = 3'd6;
            3'd4: m = 3'd1;
            3'd5: m = 3'd5;
            3'd6: m = 3'd3;
            default: m = 3'd7;
        endcase
        return CH_ZERO + 8'(m);
    endfunction

endpackage

// ----- rtl/tae_front.sv -----
// Front end: accepts requests, filters unchanged attributes and prepares decimal digits.
module tae_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tae_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output tae_pkg::t_push    o_push
);
    import tae_pkg::*;

    logic [7:0] r_last_attr;
    logic [7:0] n_last_attr;
    logic       accept;
    logic       keep;
    t_kind      kind;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        keep = 1'b0;
        kind = K_CHAR;
        case (i_in_item.req_type)
            REQ_CHAR: begin
                keep = 1'b1;
                kind = K_CHAR;
            end
            REQ_ATTR: begin
                keep = (i_in_item.attribute != r_last_attr);
                kind = K_ATTR;
            end
            REQ_CURSOR: begin
                keep = 1'b1;
                kind = K_CURSOR;
            end
            default: begin
                keep = 1'b0;
                kind = K_CHAR;
            end
        endcase
    end

    always_comb begin
        o_push.push      = accept && keep;
        o_push.desc.kind = kind;
        o_push.desc.data = (kind == K_ATTR) ? i_in_item.attribute : i_in_item.char_code;
        o_push.desc.row  = to_dec(i_in_item.row);
        o_push.desc.col  = to_dec(i_in_item.col);
    end

    // Record the attribute once it is queued for sending
    assign n_last_attr = (o_push.push && kind == K_ATTR) ? i_in_item.attribute : r_last_attr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_attr <= 8'd0;
        end else begin
            r_last_attr <= n_last_attr;
        end
    end

endmodule

// ----- rtl/tae_queue.sv -----
// Short descriptor queue between the front end and the byte emitter.
module tae_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tae_pkg::t_push  i_push,
    output logic            o_full,
    output logic            o_head_valid,
    output tae_pkg::t_desc  o_head,
    input  logic            i_pop
);
    import tae_pkg::*;

    t_desc             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/tae_back.sv -----
// Byte emitter: walks the escape template of the queue head, one byte per cycle while the receiver is ready.
module tae_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  tae_pkg::t_desc     i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tae_pkg::t_out_item o_out_item
);
    import tae_pkg::*;

    // Template positions
    localparam logic [4:0] A_RESET_END = 5'd2;
    localparam logic [4:0] A_BLINK     = 5'd3;
    localparam logic [4:0] A_BG_END    = 5'd11;
    localparam logic [4:0] A_BOLD      = 5'd12;
    localparam logic [4:0] A_FG        = 5'd16;
    localparam logic [4:0] A_LAST      = 5'd20;
    localparam logic [4:0] C_CSI_END   = 5'd1;
    localparam logic [4:0] C_ROW       = 5'd2;
    localparam logic [4:0] C_SEMI      = 5'd5;
    localparam logic [4:0] C_COL       = 5'd6;
    localparam logic [4:0] C_LAST      = 5'd9;

    logic [4:0] r_idx;
    logic [4:0] n_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       advance;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic [4:0] step_idx;
    logic [4:0] row_skip;
    logic [4:0] col_skip;

    // Leading zeros are skipped from the hundreds digit
    function automatic logic [4:0] lead_skip(input t_dec d);
        if (d.h != 2'd0) begin
            return 5'd0;
        end else if (d.t != 4'd0) begin
            return 5'd1;
        end else begin
            return 5'd2;
        end
    endfunction

    function automatic logic [7:0] dec_byte(input t_dec d, input logic [1:0] pos);
        case (pos)
            2'd0:    return CH_ZERO + 8'(d.h);
            2'd1:    return CH_ZERO + 8'(d.t);
            default: return CH_ZERO + 8'(d.o);
        endcase
    endfunction

    assign row_skip = lead_skip(i_head.row);
    assign col_skip = lead_skip(i_head.col);

    always_comb begin
        cur_byte = CH_ESC;
        cur_last = 1'b0;
        step_idx = r_idx + 5'd1;
        case (i_head.kind)
            K_CHAR: begin
                cur_byte = i_head.data;
                cur_last = 1'b1;
            end
            K_ATTR: begin
                case (r_idx)
                    5'd0, 5'd3, 5'd7, 5'd12, 5'd16: cur_byte = CH_ESC;
                    5'd1, 5'd4, 5'd8, 5'd13, 5'd17: cur_byte = CH_LBRK;
                    5'd5:    cur_byte = CH_FIVE;
                    5'd9:    cur_byte = CH_FOUR;
                    5'd10:   cur_byte = colour_digit(i_head.data[6:4]);
                    5'd14:   cur_byte = CH_ONE;
                    5'd18:   cur_byte = CH_THREE;
                    5'd19:   cur_byte = colour_digit(i_head.data[2:0]);
                    default: cur_byte = CH_M;
                endcase
                cur_last = (r_idx == A_LAST);
                if (r_idx == A_RESET_END) begin
                    step_idx = i_head.data[7] ? A_BLINK : A_BG_END - 5'd4;
                end else if (r_idx == A_BG_END) begin
                    step_idx = i_head.data[3] ? A_BOLD : A_FG;
                end
            end
            K_CURSOR: begin
                case (r_idx)
                    5'd0:    cur_byte = CH_ESC;
                    5'd1:    cur_byte = CH_LBRK;
                    5'd2:    cur_byte = dec_byte(i_head.row, 2'd0);
                    5'd3:    cur_byte = dec_byte(i_head.row, 2'd1);
                    5'd4:    cur_byte = dec_byte(i_head.row, 2'd2);
                    5'd5:    cur_byte = CH_SEMI;
                    5'd6:    cur_byte = dec_byte(i_head.col, 2'd0);
                    5'd7:    cur_byte = dec_byte(i_head.col, 2'd1);
                    5'd8:    cur_byte = dec_byte(i_head.col, 2'd2);
                    default: cur_byte = CH_H;
                endcase
                cur_last = (r_idx == C_LAST);
                if (r_idx == C_CSI_END) begin
                    step_idx = C_ROW + row_skip;
                end else if (r_idx == C_SEMI) begin
                    step_idx = C_COL + col_skip;
                end
            end
            default: begin
                cur_byte = i_head.data;
                cur_last = 1'b1;
            end
        endcase
    end

    assign advance = i_head_valid && (!r_out_valid || i_out_ready);
    assign o_pop   = advance && cur_last;
    assign n_idx   = advance ? (cur_last ? 5'd0 : step_idx) : r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.out_byte  <= cur_byte;
            r_out.last_byte <= cur_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/text_attribute_to_ansi_escape.sv -----
// Top level of the console request to ANSI escape byte-stream encoder.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one console request
// per transaction: write character, set attribute or set cursor position.
// Output channel (o_out_valid / i_out_ready / o_out_item) delivers one terminal
// byte per transaction; last_byte marks the final byte of a request.
// A request that emits nothing (unchanged attribute, unused code) is taken and dropped.
// With the emitter idle, the first byte of a request passes through the queue
// and the emitter's output register before it is offered.
// Throughput: one output byte per cycle while the receiver is ready, set by the emitter's output register.
// A character emits 1 byte, a cursor move 6 to 10, an attribute change 13 to 21.
// A two-entry queue lets requests be taken while earlier ones are still emitted;
// o_in_ready drops only when that queue is full.
// When the receiver stalls, the offered byte holds and the emitter pauses.
// Synchronous active-low reset empties the queue, clears the output and sets
// the last attribute sent to zero.
module text_attribute_to_ansi_escape (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tae_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tae_pkg::t_out_item o_out_item
);
    import tae_pkg::*;

    t_push push;
    logic  q_full;
    logic  head_valid;
    t_desc head;
    logic  pop;

    tae_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    tae_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    tae_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the console request to ANSI escape byte-stream encoder.
`timescale 1ns / 1ps

module tb_top;
    import tae_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 480;
    localparam int CALM_ITEMS     = 60;
    localparam int SQUEEZE_AT     = 60;
    localparam int SQUEEZE_CYCLES = 150;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;

    // Predicts the terminal byte stream and checks the bytes that come out
    class escape_stream_checker;
        // ANSI colour digit for each 3-bit BIOS colour, entry c at bits 3c+2..3c
        localparam logic [23:0] COLOUR_MAP = {3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4, 3'd0};

        t_out_item  pending_bytes[$];
        logic [7:0] sent_attr;
        logic [7:0] seq[$];
        int         errors;
        int         n_chars;
        int         n_attr_changes;
        int         n_cursor_moves;
        int         n_dropped;
        int         n_bytes;

        function new();
            sent_attr      = '0;
            errors         = 0;
            n_chars        = 0;
            n_attr_changes = 0;
            n_cursor_moves = 0;
            n_dropped      = 0;
            n_bytes        = 0;
        endfunction

        function void add_csi(logic [7:0] b);
            seq.push_back(CH_ESC);
            seq.push_back(CH_LBRK);
            seq.push_back(b);
        endfunction

        function logic [7:0] colour_byte(logic [2:0] c);
            return CH_ZERO + 8'(COLOUR_MAP[int'(c) * 3 +: 3]);
        endfunction

        // Decimal without leading zeros
        function void add_number(int v);
            int hundreds;
            int tens;
            hundreds = v / 100;
            tens     = (v / 10) % 10;
            if (hundreds != 0)
                seq.push_back(CH_ZERO + 8'(hundreds));
            if (hundreds != 0 || tens != 0)
                seq.push_back(CH_ZERO + 8'(tens));
            seq.push_back(CH_ZERO + 8'(v % 10));
        endfunction

        function int note_request(t_in_item it);
            t_out_item e;
            seq.delete();
            case (it.req_type)
                REQ_CHAR: begin
                    seq.push_back(it.char_code);
                    n_chars++;
                end
                REQ_ATTR: begin
                    if (it.attribute != sent_attr) begin
                        sent_attr = it.attribute;
                        n_attr_changes++;
                        add_csi(CH_M);
                        if (it.attribute[7]) begin
                            add_csi(CH_FIVE);
                            seq.push_back(CH_M);
                        end
                        add_csi(CH_FOUR);
                        seq.push_back(colour_byte(it.attribute[6:4]));
                        seq.push_back(CH_M);
                        if (it.attribute[3]) begin
                            add_csi(CH_ONE);
                            seq.push_back(CH_M);
                        end
                        add_csi(CH_THREE);
                        seq.push_back(colour_byte(it.attribute[2:0]));
                        seq.push_back(CH_M);
                    end
                end
                REQ_CURSOR: begin
                    n_cursor_moves++;
                    seq.push_back(CH_ESC);
                    seq.push_back(CH_LBRK);
                    add_number(int'(it.row) + 1);
                    seq.push_back(CH_SEMI);
                    add_number(int'(it.col) + 1);
                    seq.push_back(CH_H);
                end
                default: ;
            endcase
            if (seq.size() == 0)
                n_dropped++;
            foreach (seq[k]) begin
                e.out_byte  = seq[k];
                e.last_byte = (k == seq.size() - 1);
                pending_bytes.push_back(e);
            end
            return seq.size();
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_byte(t_out_item got);
            t_out_item want;
            n_bytes++;
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("byte 0x%02h last=%0b with nothing expected",
                                          got.out_byte, got.last_byte));
                return;
            end
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                          got.out_byte, want.out_byte));
            if (got.last_byte !== want.last_byte)
                report_mismatch($sformatf("last_byte %0b, expected %0b on byte 0x%02h",
                                          got.last_byte, want.last_byte, want.out_byte));
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    escape_stream_checker board;
    int   items_taken   = 0;
    int   idle_cycles   = 0;
    logic calm          = 1'b0;

    always #10 i_clk = ~i_clk;

    text_attribute_to_ansi_escape uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    function automatic t_in_item make_req(logic [1:0] kind, logic [7:0] ch, logic [7:0] attr,
                                          logic [7:0] row, logic [7:0] col);
        t_in_item it;
        it.req_type  = kind;
        it.char_code = ch;
        it.attribute = attr;
        it.row       = row;
        it.col       = col;
        return it;
    endfunction

    // Mix one-, two- and three-digit cursor numbers
    function automatic logic [7:0] pick_coord();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(0, 8));
            1:       return 8'($urandom_range(0, 98));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_request();
        t_in_item it;
        int       pick;
        it   = make_req(REQ_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.req_type = REQ_CHAR;
        end else if (pick < 75) begin
            it.req_type = REQ_ATTR;
            if ($urandom_range(0, 4) == 0)
                it.attribute = board.sent_attr;
        end else if (pick < 95) begin
            it.req_type = REQ_CURSOR;
            it.row      = pick_coord();
            it.col      = pick_coord();
        end
        return it;
    endfunction

    task automatic send_request(input t_in_item it);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_taken++;
        void'(board.note_request(it));
    endtask

    initial begin : stimulus
        board = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Attribute 0 straight after reset matches the cleared state: nothing out
        send_request(make_req(REQ_ATTR, 8'hFF, 8'h00, 8'hFF, 8'hFF));
        send_request(make_req(REQ_CHAR, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_req(REQ_CHAR, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_request(make_req(REQ_CHAR, CH_ESC, 8'h5A, 8'hA5, 8'h3C));
        send_request(make_req(REQ_ATTR, 8'h00, 8'hFF, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h80, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h08, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h70, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h07, 8'h00, 8'h00));
        // Walk colours 0 to 6 through the background and 1 to 7 through the foreground
        send_request(make_req(REQ_ATTR, 8'h00, 8'h01, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h12, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h23, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h34, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h45, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'h56, 8'h00, 8'h00));
        send_request(make_req(REQ_ATTR, 8'h00, 8'hE7, 8'h00, 8'h00));
        send_request(make_req(REQ_CURSOR, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 8'hFF, 8'hFF));
        send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 8'd8, 8'd9));
        send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 8'd98, 8'd99));
        send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 8'd199, 8'd109));
        send_request(make_req(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

        while (items_taken < RANDOM_ITEMS) begin
            if (items_taken >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_request(random_request());
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (board.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d characters, %0d attribute changes, %0d cursor moves,",
                 items_taken, board.n_chars, board.n_attr_changes, board.n_cursor_moves);
        $display("%0d dropped; %0d bytes checked, one %0d-cycle output hold-off included.",
                 board.n_dropped, board.n_bytes, SQUEEZE_CYCLES);
        if (board.errors == 0)
            $display("PASS text_attribute_to_ansi_escape");
        else
            $display("FAIL text_attribute_to_ansi_escape");
        $finish;
    end

    // Output side: random stalls, one long hold-off to back up the input queue
    initial begin : receiver
        int   hold;
        logic squeezed;
        hold     = 0;
        squeezed = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!squeezed && items_taken >= SQUEEZE_AT) begin
                squeezed = 1'b1;
                hold     = SQUEEZE_CYCLES;
            end else if (hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 11);
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_byte(o_out_item);
    end

    // Give up when neither channel completes a transaction for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d bytes outstanding",
                         STALL_LIMIT, board.pending_bytes.size());
                $display("FAIL text_attribute_to_ansi_escape");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
